// ===== design/hsv_to_rgb_converter_core_macros.svh =====
// Assertion macros for the HSV to RGB converter checker.
// Relies on clk_i and rst_ni being visible where the macros are used.
`ifndef HSV_TO_RGB_CONVERTER_CORE_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HSV2RGB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hsv2rgb checker: same-cycle property failed");

// Consequent must hold in the cycle after the antecedent.
`define HSV2RGB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hsv2rgb checker: next-cycle property failed");

`endif

// ===== design/hsv2rgb_pkg.sv =====
// Shared constants and types of the HSV to RGB converter.
// No dependencies; used by every design module of the block except the checker.
package hsv2rgb_pkg;

  // Hue arithmetic in 1/16 degree.
  localparam int unsigned HueW       = 16;
  localparam int unsigned HueFull    = 5760;  // 360 degrees
  localparam int unsigned HueSector  = 960;   // 60 degrees
  localparam int unsigned HueOffset  = 1792;  // brings offset-binary hue onto the residue
  localparam int unsigned HueWrapMax = 11;    // largest whole turn count after the offset
  localparam int unsigned HueRedW    = 13;    // reduced hue, 0..5759
  localparam int unsigned FracW      = 10;    // sector coefficient, 0..960

  // Percent inputs.
  localparam int unsigned PctW    = 7;
  localparam int unsigned PctFull = 100;

  // Channel arithmetic: x = floor((V*(96000 - S*k)*4369 + 320000) / 640000).
  localparam int unsigned DiffW       = 17;
  localparam int unsigned ChanNumBase = 96000;
  localparam int unsigned ProdW       = 24;
  localparam int unsigned ScaleMul    = 4369;
  localparam int unsigned ScaleMulW   = 13;
  localparam int unsigned RoundAdd    = 320000;
  localparam int unsigned ScaleShift  = 10;
  localparam int unsigned ScaledW     = 26;
  localparam int unsigned RecipMul    = 109951163;  // ceil(2^36 / 625)
  localparam int unsigned RecipW      = 27;
  localparam int unsigned RecipShift  = 36;
  localparam int unsigned SatLimit    = 40960000;   // 65536 * 625
  localparam int unsigned ChanW       = 16;

  localparam int unsigned QueueDepth = 4;

  typedef logic [FracW-1:0] coef_t;

  // One classified colour: clamped saturation, value and the coefficient of each channel.
  typedef struct packed {
    logic [PctW-1:0] sat;
    logic [PctW-1:0] val;
    coef_t           k_red;
    coef_t           k_green;
    coef_t           k_blue;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_beat_t;

endpackage

// ===== design/hsv_to_rgb_converter_core.sv =====
// HSV to RGB converter, top level: front end, job queue and back end.
// An accepted input beat passes the front-end stages, the job queue and the back-end stages to the output.
// Throughput: one beat per clock cycle while the queue has room and the output side takes results.
// Reset: rst_ni clears all valid flags and queue pointers at once; no clearing pass.
// Depends on hsv2rgb_pkg, hsv2rgb_front, hsv2rgb_fifo and hsv2rgb_back.
module hsv_to_rgb_converter_core #(
  parameter int unsigned FifoDepth = hsv2rgb_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [15:0] hue, [22:16] saturation, [29:23] brightness
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o    // [15:0] red, [31:16] green, [47:32] blue
);

  // The front end reduces the hue modulo 360 degrees in its first stage and, in its second,
  // splits it into a 60-degree sector and a fraction. The sector decides which coefficient
  // each colour channel uses (zero for v, the whole sector for p, the fraction for q and
  // its complement for t), so the back end only ever computes three channels.
  //
  // The queue decouples the two halves: the input side is held only when the queue is full,
  // and its ready depends on registered state alone, never on the output's tready.
  //
  // Each back-end lane evaluates round(V*(96000 - S*k)*65535 / 9600000) in four stages:
  // one multiplier per stage, the final division by 625 done by an exact reciprocal
  // multiplication, with saturation at full scale.

  hsv2rgb_pkg::job_beat_t front_beat;
  hsv2rgb_pkg::job_beat_t back_beat;
  logic                   queue_full;
  logic                   queue_pop;
  logic [hsv2rgb_pkg::ChanW-1:0] red, green, blue;

  hsv2rgb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .hue_i      (s_axis_tdata_i[15:0]),
    .sat_i      (s_axis_tdata_i[22:16]),
    .val_i      (s_axis_tdata_i[29:23]),
    .full_i     (queue_full),
    .out_o      (front_beat)
  );

  hsv2rgb_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (front_beat),
    .full_o (queue_full),
    .pop_i  (queue_pop),
    .out_o  (back_beat)
  );

  hsv2rgb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (back_beat),
    .pop_o       (queue_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .red_o       (red),
    .green_o     (green),
    .blue_o      (blue)
  );

  assign m_axis_tdata_o = {blue, green, red};

endmodule

// ===== design/hsv2rgb_front.sv =====
// Front end of the HSV to RGB converter: hue reduction, sector split, coefficient choice.
// Depends on hsv2rgb_pkg.
module hsv2rgb_front (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [hsv2rgb_pkg::HueW-1:0]   hue_i,
  input  logic        [hsv2rgb_pkg::PctW-1:0]   sat_i,
  input  logic        [hsv2rgb_pkg::PctW-1:0]   val_i,
  input  logic                                  full_i,
  output hsv2rgb_pkg::job_beat_t                out_o
);

  typedef enum logic [2:0] {
    SecRedYel, SecYelGrn, SecGrnCyn, SecCynBlu, SecBluMag, SecMagRed
  } sector_e;

  localparam int unsigned WrapW = hsv2rgb_pkg::HueW + 1;

  logic                                 adv;
  logic [WrapW-1:0]                     wrap_w;
  logic [WrapW-1:0]                     wrap_sub;
  logic [hsv2rgb_pkg::PctW-1:0]         sat_clamp;

  logic                                 s1_valid_q;
  logic [hsv2rgb_pkg::HueRedW-1:0]      s1_hue_q;
  logic [hsv2rgb_pkg::PctW-1:0]         s1_sat_q;
  logic [hsv2rgb_pkg::PctW-1:0]         s1_val_q;

  logic [2:0]                           sec_idx;
  logic [hsv2rgb_pkg::HueRedW-1:0]      sec_base;
  hsv2rgb_pkg::coef_t                   frac;
  hsv2rgb_pkg::coef_t                   rise;
  hsv2rgb_pkg::coef_t                   fall;
  hsv2rgb_pkg::coef_t                   span;
  hsv2rgb_pkg::job_t                    job_d;

  logic                                 s2_valid_q;
  hsv2rgb_pkg::job_t                    s2_job_q;

  // Both stages move together; they hold only when a finished job cannot enter the queue.
  assign adv        = !s2_valid_q || !full_i;
  assign in_ready_o = adv;

  // Offset-binary hue plus a constant lands on the same residue modulo 360 degrees.
  assign wrap_w = {1'b0, ~hue_i[hsv2rgb_pkg::HueW-1], hue_i[hsv2rgb_pkg::HueW-2:0]}
                + WrapW'(hsv2rgb_pkg::HueOffset);

  always_comb begin
    wrap_sub = '0;
    for (int j = 1; j <= int'(hsv2rgb_pkg::HueWrapMax); j++) begin
      if (wrap_w >= WrapW'(j * hsv2rgb_pkg::HueFull)) begin
        wrap_sub = WrapW'(j * hsv2rgb_pkg::HueFull);
      end
    end
  end

  assign sat_clamp = (sat_i > hsv2rgb_pkg::PctW'(hsv2rgb_pkg::PctFull))
                   ? hsv2rgb_pkg::PctW'(hsv2rgb_pkg::PctFull) : sat_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      s1_hue_q <= hsv2rgb_pkg::HueRedW'(wrap_w - wrap_sub);
      s1_sat_q <= sat_clamp;
      s1_val_q <= val_i;
    end
    if (adv && s1_valid_q) begin
      s2_job_q <= job_d;
    end
  end

  // Sector number and the fraction within it.
  always_comb begin
    sec_idx  = '0;
    sec_base = '0;
    for (int j = 1; j < 6; j++) begin
      if (s1_hue_q >= hsv2rgb_pkg::HueRedW'(j * hsv2rgb_pkg::HueSector)) begin
        sec_idx  = 3'(j);
        sec_base = hsv2rgb_pkg::HueRedW'(j * hsv2rgb_pkg::HueSector);
      end
    end
  end

  assign frac = hsv2rgb_pkg::FracW'(s1_hue_q - sec_base);
  assign span = hsv2rgb_pkg::FracW'(hsv2rgb_pkg::HueSector);
  assign rise = frac;
  assign fall = span - frac;

  // Coefficient 0 gives v, the full sector gives p, the fraction q and its complement t.
  always_comb begin
    job_d.sat = s1_sat_q;
    job_d.val = s1_val_q;
    unique case (sec_idx)
      SecRedYel: begin
        job_d.k_red = '0;   job_d.k_green = fall; job_d.k_blue = span;
      end
      SecYelGrn: begin
        job_d.k_red = rise; job_d.k_green = '0;   job_d.k_blue = span;
      end
      SecGrnCyn: begin
        job_d.k_red = span; job_d.k_green = '0;   job_d.k_blue = fall;
      end
      SecCynBlu: begin
        job_d.k_red = span; job_d.k_green = rise; job_d.k_blue = '0;
      end
      SecBluMag: begin
        job_d.k_red = fall; job_d.k_green = span; job_d.k_blue = '0;
      end
      default: begin
        job_d.k_red = '0;   job_d.k_green = span; job_d.k_blue = rise;
      end
    endcase
  end

  assign out_o.valid = s2_valid_q;
  assign out_o.job   = s2_job_q;

endmodule

// ===== design/hsv2rgb_fifo.sv =====
// Short job queue between the front and back ends of the HSV to RGB converter.
// Depends on hsv2rgb_pkg.
module hsv2rgb_fifo #(
  parameter int unsigned Depth = hsv2rgb_pkg::QueueDepth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  hsv2rgb_pkg::job_beat_t in_i,
  output logic                   full_o,
  input  logic                   pop_i,
  output hsv2rgb_pkg::job_beat_t out_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  hsv2rgb_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              push;
  logic              pop;

  assign full_o = (count_q == CntW'(Depth));
  assign push   = in_i.valid && !full_o;
  assign pop    = pop_i && (count_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_i.job;
    end
  end

  assign out_o.valid = (count_q != '0);
  assign out_o.job   = mem_q[rd_ptr_q];

endmodule

// ===== design/hsv2rgb_back.sv =====
// Back end of the HSV to RGB converter: three channel lanes and the output register.
// Depends on hsv2rgb_pkg.
module hsv2rgb_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  hsv2rgb_pkg::job_beat_t              in_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [hsv2rgb_pkg::ChanW-1:0]       red_o,
  output logic [hsv2rgb_pkg::ChanW-1:0]       green_o,
  output logic [hsv2rgb_pkg::ChanW-1:0]       blue_o
);

  localparam int unsigned Lanes  = 3;
  localparam int unsigned NumW   = hsv2rgb_pkg::ProdW + hsv2rgb_pkg::ScaleMulW;
  localparam int unsigned RecipPW = hsv2rgb_pkg::ScaledW + hsv2rgb_pkg::RecipW;

  logic                                 adv;
  logic                                 b1_valid_q, b2_valid_q, b3_valid_q, b4_valid_q;
  logic [hsv2rgb_pkg::PctW-1:0]         b1_val_q;
  hsv2rgb_pkg::coef_t                   coef      [Lanes];
  logic [hsv2rgb_pkg::DiffW-1:0]        diff_q    [Lanes];
  logic [hsv2rgb_pkg::ProdW-1:0]        prod_q    [Lanes];
  logic [hsv2rgb_pkg::ScaledW-1:0]      scaled_q  [Lanes];
  logic [hsv2rgb_pkg::ChanW-1:0]        chan_q    [Lanes];

  // The whole back end moves as one; only a result left untaken holds it.
  assign adv   = !b4_valid_q || out_ready_i;
  assign pop_o = in_i.valid && adv;

  assign coef[0] = in_i.job.k_red;
  assign coef[1] = in_i.job.k_green;
  assign coef[2] = in_i.job.k_blue;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q <= 1'b0;
      b2_valid_q <= 1'b0;
      b3_valid_q <= 1'b0;
      b4_valid_q <= 1'b0;
    end else if (adv) begin
      b1_valid_q <= in_i.valid;
      b2_valid_q <= b1_valid_q;
      b3_valid_q <= b2_valid_q;
      b4_valid_q <= b3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_i.valid) begin
      b1_val_q <= in_i.job.val;
    end
  end

  for (genvar l = 0; l < Lanes; l++) begin : g_lane
    logic [hsv2rgb_pkg::DiffW-1:0]   sk;
    logic [NumW-1:0]                 num;
    logic [RecipPW-1:0]              recip;
    logic                            sat_hit;

    assign sk = hsv2rgb_pkg::DiffW'(in_i.job.sat) * hsv2rgb_pkg::DiffW'(coef[l]);
    assign num = NumW'(prod_q[l]) * NumW'(hsv2rgb_pkg::ScaleMul)
               + NumW'(hsv2rgb_pkg::RoundAdd);
    assign recip = RecipPW'(scaled_q[l]) * RecipPW'(hsv2rgb_pkg::RecipMul);
    assign sat_hit = (scaled_q[l] >= hsv2rgb_pkg::ScaledW'(hsv2rgb_pkg::SatLimit));

    always_ff @(posedge clk_i) begin
      if (adv) begin
        // 96000 - S*k never goes negative: S is clamped to 100 and k is at most 960.
        diff_q[l]   <= hsv2rgb_pkg::DiffW'(hsv2rgb_pkg::ChanNumBase) - sk;
        prod_q[l]   <= hsv2rgb_pkg::ProdW'(b1_val_q) * hsv2rgb_pkg::ProdW'(diff_q[l]);
        scaled_q[l] <= num[hsv2rgb_pkg::ScaleShift +: hsv2rgb_pkg::ScaledW];
        chan_q[l]   <= sat_hit ? '1 : recip[hsv2rgb_pkg::RecipShift +: hsv2rgb_pkg::ChanW];
      end
    end
  end

  assign out_valid_o = b4_valid_q;
  assign red_o       = chan_q[0];
  assign green_o     = chan_q[1];
  assign blue_o      = chan_q[2];

endmodule

// ===== design/hsv2rgb_checker.sv =====
// Port-level checker for the HSV to RGB converter, bound to the top level.
// Depends on hsv_to_rgb_converter_core_macros.svh.
`include "hsv_to_rgb_converter_core_macros.svh"

module hsv2rgb_checker #(
  parameter int unsigned IdleSpan = 24
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [47:0] m_axis_tdata_o
);

  localparam int unsigned IdleW = $clog2(IdleSpan + 1);

  logic [IdleW-1:0] idle_q;
  logic             in_beat;

  assign in_beat = s_axis_tvalid_i && s_axis_tready_o;

  // Counts cycles with the output side ready and no input beat taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_q <= '0;
    end else if (!m_axis_tready_i || in_beat) begin
      idle_q <= '0;
    end else if (idle_q != IdleW'(IdleSpan)) begin
      idle_q <= idle_q + 1'b1;
    end
  end

  `HSV2RGB_ASSERT_NEXT(a_out_valid_held, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o)
  `HSV2RGB_ASSERT_NEXT(a_out_data_held, m_axis_tvalid_o && !m_axis_tready_i, $stable(m_axis_tdata_o))
  `HSV2RGB_ASSERT_NOW(a_drains_when_idle, idle_q == IdleW'(IdleSpan), !m_axis_tvalid_o)
  `HSV2RGB_ASSERT_NOW(a_stall_has_cause, !s_axis_tready_o, $past(m_axis_tvalid_o && !m_axis_tready_i))

endmodule

bind hsv_to_rgb_converter_core hsv2rgb_checker #(
  .IdleSpan (2 * FifoDepth + 16)
) u_hsv2rgb_checker (.*);
